FILE: src/rre_pkg.sv
// Package for the RTT/RTO estimator: widths, word and control types, helpers.
// Used by the interfaces, the controller, the datapath and the top level.
package rre_pkg;

   localparam int SAMPLE_BITS = 26;
   localparam int HIST        = 5;
   localparam int TIME_W      = 48;
   localparam int OUT_W       = 32;
   localparam int KMUL_W      = 4;
   localparam int SRTT_W      = SAMPLE_BITS + 3;
   localparam int AVG_W       = SAMPLE_BITS + 16;
   localparam int LO_W        = (AVG_W + 1) / 2;
   localparam int HI_W        = AVG_W - LO_W;
   localparam int GAIN_W      = 16;
   localparam int PROD_W      = LO_W + GAIN_W;
   localparam int ACC_W       = AVG_W + GAIN_W;
   localparam int CNT_W       = $clog2(HIST + 1);
   localparam int IDX_W       = $clog2(HIST);
   localparam int ACKD_W      = 20;
   localparam int WMUL_W      = 8;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 26;
   localparam int TOLERANCE_US = 4000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OUTLIER   = 3'd0,
      CSR_ACK_DELAY = 3'd1,
      CSR_WIN_MUL   = 3'd2,
      CSR_GAIN      = 3'd3,
      CSR_MIN_RTO   = 3'd4,
      CSR_INIT_RTO  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic                   func;
      logic [TIME_W-1:0]      now_us;
      logic [SAMPLE_BITS-1:0] sample_us;
      logic [KMUL_W-1:0]      rexmit_multiplier;
   } req_word_type;

   typedef struct packed {
      logic                   estimator_ready;
      logic                   sample_used;
      logic [SAMPLE_BITS-1:0] srtt_out_us;
      logic [SAMPLE_BITS-1:0] mdev_out_us;
      logic [OUT_W-1:0]       rto_us;
      logic [OUT_W-1:0]       fast_rexmit_us;
      logic [OUT_W-1:0]       rexmit_us;
      logic [SAMPLE_BITS-1:0] rtt_min_est_us;
      logic [SAMPLE_BITS-1:0] rtt_max_est_us;
      logic [SAMPLE_BITS-1:0] owd_min_est_us;
      logic [SAMPLE_BITS-1:0] owd_max_est_us;
   } rsp_word_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_PREP,
      OP_RTT,
      OP_MUL0,
      OP_MUL1,
      OP_AVG,
      OP_WL0,
      OP_WL1,
      OP_WEND,
      OP_FILT,
      OP_SORT_LD,
      OP_SORT,
      OP_MED,
      OP_OUT
   } op_type;

   typedef struct packed {
      logic skip;
      logic is_rtt;
      logic first;
      logic need_sort;
      logic sort_last;
   } dp_status_type;

   function automatic logic [OUT_W-1:0] sat32(input logic [OUT_W+1:0] v);
      sat32 = (v[OUT_W+1:OUT_W] != 2'd0) ? {OUT_W{1'b1}} : v[OUT_W-1:0];
   endfunction

endpackage

FILE: src/rre_if.sv
// Handshake interfaces for the request, response and register write channels.
// Depends on rre_pkg for the word widths.
interface rre_req_if;
   import rre_pkg::*;
   logic                   valid;
   logic                   ready;
   logic                   func;
   logic [TIME_W-1:0]      now_us;
   logic [SAMPLE_BITS-1:0] sample_us;
   logic [KMUL_W-1:0]      rexmit_multiplier;
   modport source (output valid, func, now_us, sample_us, rexmit_multiplier, input ready);
   modport sink (input valid, func, now_us, sample_us, rexmit_multiplier, output ready);
endinterface

interface rre_rsp_if;
   import rre_pkg::*;
   logic                   valid;
   logic                   ready;
   logic                   estimator_ready;
   logic                   sample_used;
   logic [SAMPLE_BITS-1:0] srtt_out_us;
   logic [SAMPLE_BITS-1:0] mdev_out_us;
   logic [OUT_W-1:0]       rto_us;
   logic [OUT_W-1:0]       fast_rexmit_us;
   logic [OUT_W-1:0]       rexmit_us;
   logic [SAMPLE_BITS-1:0] rtt_min_est_us;
   logic [SAMPLE_BITS-1:0] rtt_max_est_us;
   logic [SAMPLE_BITS-1:0] owd_min_est_us;
   logic [SAMPLE_BITS-1:0] owd_max_est_us;
   modport source (output valid, estimator_ready, sample_used, srtt_out_us, mdev_out_us,
                   rto_us, fast_rexmit_us, rexmit_us, rtt_min_est_us, rtt_max_est_us,
                   owd_min_est_us, owd_max_est_us, input ready);
   modport sink (input valid, estimator_ready, sample_used, srtt_out_us, mdev_out_us,
                 rto_us, fast_rexmit_us, rexmit_us, rtt_min_est_us, rtt_max_est_us,
                 owd_min_est_us, owd_max_est_us, output ready);
endinterface

interface rre_csr_if;
   import rre_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: src/rre_ctrl.sv
// Sequencing state machine of the estimator: handshakes and datapath operations.
// Depends on rre_pkg for the operation and status types.
module rre_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rre_pkg::dp_status_type status,
   output rre_pkg::op_type        op
);
   import rre_pkg::*;

   typedef enum logic [13:0] {
      ST_IDLE    = 14'b00000000000001,
      ST_PREP    = 14'b00000000000010,
      ST_RTT     = 14'b00000000000100,
      ST_MUL0    = 14'b00000000001000,
      ST_MUL1    = 14'b00000000010000,
      ST_AVG     = 14'b00000000100000,
      ST_WL0     = 14'b00000001000000,
      ST_WL1     = 14'b00000010000000,
      ST_WEND    = 14'b00000100000000,
      ST_FILT    = 14'b00001000000000,
      ST_SORT_LD = 14'b00010000000000,
      ST_SORT    = 14'b00100000000000,
      ST_MED     = 14'b01000000000000,
      ST_OUT     = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      op           = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op       = OP_LOAD;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            op = OP_PREP;
            if (status.skip) state_in = ST_OUT;
            else if (status.is_rtt) state_in = ST_RTT;
            else state_in = ST_WL0;
         end
         ST_RTT: begin
            op       = OP_RTT;
            state_in = status.first ? ST_WL0 : ST_MUL0;
         end
         ST_MUL0: begin
            op       = OP_MUL0;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            op       = OP_MUL1;
            state_in = ST_AVG;
         end
         ST_AVG: begin
            op       = OP_AVG;
            state_in = ST_WL0;
         end
         ST_WL0: begin
            op       = OP_WL0;
            state_in = ST_WL1;
         end
         ST_WL1: begin
            op       = OP_WL1;
            state_in = ST_WEND;
         end
         ST_WEND: begin
            op       = OP_WEND;
            state_in = ST_FILT;
         end
         ST_FILT: begin
            op       = OP_FILT;
            state_in = status.need_sort ? ST_SORT_LD : ST_OUT;
         end
         ST_SORT_LD: begin
            op       = OP_SORT_LD;
            state_in = ST_SORT;
         end
         ST_SORT: begin
            op = OP_SORT;
            if (status.sort_last) state_in = ST_MED;
         end
         ST_MED: begin
            op       = OP_MED;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // The result register must be empty, or emptied in this cycle.
            if (rsp_free) begin
               op           = OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: src/rre_dpath.sv
// Datapath of the estimator: registers, smoothed RTT, slow average, filters, median.
// Depends on rre_pkg; driven by the operation code from rre_ctrl.
module rre_dpath (
   input  logic                           clock,
   input  logic                           reset,
   input  rre_pkg::op_type                op,
   input  rre_pkg::req_word_type          req_word,
   input  logic                           csr_write,
   input  logic [rre_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rre_pkg::CSR_DATA_W-1:0] csr_data,
   output rre_pkg::dp_status_type         status,
   output rre_pkg::rsp_word_type          rsp_word
);
   import rre_pkg::*;

   typedef logic [SAMPLE_BITS-1:0] smp_type;

   // Configuration registers.
   logic              rej_ff;
   logic [ACKD_W-1:0] ackd_ff;
   logic [WMUL_W-1:0] wmul_ff;
   logic [GAIN_W-1:0] gain_ff;
   smp_type           min_rto_ff, init_rto_ff;

   req_word_type      item_ff, item_in;
   logic              used_ff, used_in;
   logic              have_ff, have_in;
   logic [SRTT_W-1:0] srtt_ff, srtt_in, mdev_ff, mdev_in;
   logic [AVG_W-1:0]  avg_ff, avg_in, diff_ff, diff_in;
   logic              up_ff, up_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [TIME_W-1:0] wcand_ff, wcand_in;

   logic              started_ff [2], started_in [2];
   smp_type           wmin_ff [2], wmin_in [2], wmax_ff [2], wmax_in [2];
   logic [TIME_W-1:0] wend_ff [2], wend_in [2];
   smp_type           mine_ff [2], mine_in [2], maxe_ff [2], maxe_in [2];
   logic [CNT_W-1:0]  cnt_ff [2], cnt_in [2];
   smp_type           hmin_ff [2][HIST], hmin_in [2][HIST];
   smp_type           hmax_ff [2][HIST], hmax_in [2][HIST];
   smp_type           buf_ff [HIST], buf_in [HIST];
   logic [IDX_W-1:0]  pass_ff, pass_in;
   rsp_word_type      rsp_ff, rsp_in;

   // Working signals.
   logic              f;
   smp_type           s;
   logic [SRTT_W-1:0] s3, err;
   logic [AVG_W-1:0]  x;
   logic [31:0]       mdev_sum, srtt_sum;
   logic [LO_W-1:0]   mul_a;
   logic [GAIN_W-1:0] mul_b;
   logic [PROD_W-1:0] prod;
   logic [AVG_W-1:0]  delta;
   logic [TIME_W:0]   wsum;
   logic              in_win, rej_f;
   smp_type           min2, max2;
   logic [CNT_W-1:0]  mid;
   logic [IDX_W-1:0]  mid_idx, lo_idx;
   logic [SAMPLE_BITS:0] med_sum;
   logic [SRTT_W+2:0] fast_sum;
   logic [SRTT_W+KMUL_W+1:0] rex_sum;
   logic [OUT_W+1:0]  fast_w, rto_w, rex_w;

   assign f      = item_ff.func;
   assign s      = item_ff.sample_us;
   assign s3     = {s, 3'b000};
   assign x      = {s, 16'd0};
   assign err    = (srtt_ff > s3) ? (srtt_ff - s3) : (s3 - srtt_ff);
   assign mdev_sum = 32'(3 * {3'b000, mdev_ff}) + 32'(err);
   assign srtt_sum = 32'((32'(7) * 32'(srtt_ff)) >> 3) + 32'(s);
   assign delta  = acc_ff[GAIN_W +: AVG_W];
   assign wsum   = {1'b0, item_ff.now_us} + (TIME_W + 1)'(acc_ff[ACC_W-1:20]);
   assign in_win = item_ff.now_us < wend_ff[f];
   assign rej_f  = rej_ff && !f;

   // One 21 by 16 multiplier serves the average gain and the window length.
   always_comb begin
      mul_a = '0;
      mul_b = gain_ff;
      case (op)
         OP_MUL0: mul_a = diff_ff[LO_W-1:0];
         OP_MUL1: mul_a = LO_W'(diff_ff[AVG_W-1:LO_W]);
         OP_WL0: begin
            mul_a = avg_ff[LO_W-1:0];
            mul_b = GAIN_W'(wmul_ff);
         end
         OP_WL1: begin
            mul_a = LO_W'(avg_ff[AVG_W-1:LO_W]);
            mul_b = GAIN_W'(wmul_ff);
         end
         default: mul_a = '0;
      endcase
   end
   assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

   // Estimates of the two most recent windows once the current one is pushed.
   always_comb begin
      if (cnt_ff[f] == '0) begin
         min2 = wmin_ff[f];
         max2 = wmax_ff[f];
      end else begin
         min2 = (hmin_ff[f][0] < wmin_ff[f]) ? hmin_ff[f][0] : wmin_ff[f];
         max2 = (hmax_ff[f][0] > wmax_ff[f]) ? hmax_ff[f][0] : wmax_ff[f];
      end
   end

   assign mid     = cnt_ff[0] >> 1;
   assign mid_idx = mid[IDX_W-1:0];
   assign lo_idx  = mid_idx - IDX_W'(1);
   assign med_sum = {1'b0, buf_ff[lo_idx]} + {1'b0, buf_ff[mid_idx]};

   assign fast_sum = (SRTT_W + 3)'(srtt_ff) + {1'b0, mdev_ff, 2'b00};
   assign rex_sum  = (SRTT_W + KMUL_W + 2)'(srtt_ff)
                   + (SRTT_W + KMUL_W + 2)'(item_ff.rexmit_multiplier)
                     * (SRTT_W + KMUL_W + 2)'(mdev_ff);
   assign fast_w   = (OUT_W + 2)'(fast_sum >> 3);
   assign rto_w    = fast_w + (OUT_W + 2)'(ackd_ff) + (OUT_W + 2)'(TOLERANCE_US);
   assign rex_w    = (OUT_W + 2)'(rex_sum >> 3) + (OUT_W + 2)'(ackd_ff)
                   + (OUT_W + 2)'(TOLERANCE_US);

   always_comb begin
      item_in    = item_ff;
      used_in    = used_ff;
      have_in    = have_ff;
      srtt_in    = srtt_ff;
      mdev_in    = mdev_ff;
      avg_in     = avg_ff;
      diff_in    = diff_ff;
      up_in      = up_ff;
      acc_in     = acc_ff;
      wcand_in   = wcand_ff;
      started_in = started_ff;
      wmin_in    = wmin_ff;
      wmax_in    = wmax_ff;
      wend_in    = wend_ff;
      mine_in    = mine_ff;
      maxe_in    = maxe_ff;
      cnt_in     = cnt_ff;
      hmin_in    = hmin_ff;
      hmax_in    = hmax_ff;
      buf_in     = buf_ff;
      pass_in    = pass_ff;
      rsp_in     = rsp_ff;
      case (op)
         OP_LOAD: item_in = req_word;
         OP_PREP: used_in = !status.skip;
         OP_RTT: begin
            if (!have_ff) begin
               have_in = 1'b1;
               srtt_in = s3;
               mdev_in = SRTT_W'({s, 2'b00});
               avg_in  = x;
            end else begin
               mdev_in = mdev_sum[SRTT_W+1:2];
               srtt_in = srtt_sum[SRTT_W-1:0];
               up_in   = avg_ff < x;
               diff_in = (avg_ff >= x) ? (avg_ff - x) : (x - avg_ff);
            end
         end
         OP_MUL0, OP_WL0: acc_in = ACC_W'(prod);
         OP_MUL1, OP_WL1: acc_in = acc_ff + (ACC_W'(prod) << LO_W);
         OP_AVG: avg_in = up_ff ? (avg_ff + delta) : (avg_ff - delta);
         OP_WEND: wcand_in = wsum[TIME_W] ? {TIME_W{1'b1}} : wsum[TIME_W-1:0];
         OP_FILT: begin
            if (!started_ff[f]) begin
               started_in[f] = 1'b1;
               wmin_in[f]    = s;
               wmax_in[f]    = s;
               wend_in[f]    = wcand_ff;
               mine_in[f]    = s;
               maxe_in[f]    = s;
            end else if (in_win) begin
               if (s < wmin_ff[f]) wmin_in[f] = s;
               if (s > wmax_ff[f]) wmax_in[f] = s;
               if (s < mine_ff[f]) mine_in[f] = s;
               if (!rej_f && s > maxe_ff[f]) maxe_in[f] = s;
            end else begin
               // Close the window: newest history entry sits at position zero.
               hmin_in[f][0] = wmin_ff[f];
               hmax_in[f][0] = wmax_ff[f];
               for (int i = 1; i < HIST; i++) begin
                  hmin_in[f][i] = hmin_ff[f][i-1];
                  hmax_in[f][i] = hmax_ff[f][i-1];
               end
               if (cnt_ff[f] < CNT_W'(HIST)) cnt_in[f] = cnt_ff[f] + CNT_W'(1);
               wmin_in[f] = s;
               wmax_in[f] = s;
               wend_in[f] = wcand_ff;
               mine_in[f] = (s < min2) ? s : min2;
               if (!rej_f) maxe_in[f] = (s > max2) ? s : max2;
            end
         end
         OP_SORT_LD: begin
            // Unused slots hold the largest value so they sort to the top.
            for (int i = 0; i < HIST; i++) begin
               buf_in[i] = (CNT_W'(i) < cnt_ff[0]) ? hmax_ff[0][i] : {SAMPLE_BITS{1'b1}};
            end
            pass_in = '0;
         end
         OP_SORT: begin
            // One odd-even transposition pass per cycle.
            for (int i = 0; i < HIST - 1; i++) begin
               if ((i % 2) == int'(pass_ff[0]) && buf_ff[i] > buf_ff[i+1]) begin
                  buf_in[i]   = buf_ff[i+1];
                  buf_in[i+1] = buf_ff[i];
               end
            end
            pass_in = pass_ff + IDX_W'(1);
         end
         OP_MED: begin
            maxe_in[0] = cnt_ff[0][0] ? buf_ff[mid_idx] : med_sum[SAMPLE_BITS:1];
         end
         OP_OUT: begin
            rsp_in.estimator_ready = have_ff;
            rsp_in.sample_used     = used_ff;
            rsp_in.srtt_out_us     = srtt_ff[SRTT_W-1:3];
            rsp_in.mdev_out_us     = mdev_ff[SRTT_W-1:3];
            if (!have_ff) begin
               rsp_in.rto_us         = OUT_W'(init_rto_ff);
               rsp_in.fast_rexmit_us = OUT_W'(init_rto_ff);
               rsp_in.rexmit_us      = OUT_W'(init_rto_ff);
            end else begin
               rsp_in.rto_us = (rto_w < (OUT_W + 2)'(min_rto_ff)) ? OUT_W'(min_rto_ff)
                                                                  : sat32(rto_w);
               rsp_in.fast_rexmit_us = sat32(fast_w);
               rsp_in.rexmit_us      = sat32(rex_w);
            end
            rsp_in.rtt_min_est_us = mine_ff[0];
            rsp_in.rtt_max_est_us = maxe_ff[0];
            rsp_in.owd_min_est_us = mine_ff[1];
            rsp_in.owd_max_est_us = maxe_ff[1];
         end
         default: used_in = used_ff;
      endcase
   end

   assign status.skip      = (s == '0) || (f && !have_ff);
   assign status.is_rtt    = !f;
   assign status.first     = !have_ff;
   assign status.need_sort = started_ff[f] && !in_win && rej_f;
   assign status.sort_last = (pass_ff == IDX_W'(HIST - 1));
   assign rsp_word         = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rej_ff      <= 1'b0;
         ackd_ff     <= ACKD_W'(5000);
         wmul_ff     <= WMUL_W'(32);
         gain_ff     <= GAIN_W'(655);
         min_rto_ff  <= SAMPLE_BITS'(200000);
         init_rto_ff <= SAMPLE_BITS'(1000000);
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_OUTLIER:   rej_ff      <= csr_data[0];
            CSR_ACK_DELAY: ackd_ff     <= csr_data[ACKD_W-1:0];
            CSR_WIN_MUL:   wmul_ff     <= csr_data[WMUL_W-1:0];
            CSR_GAIN:      gain_ff     <= csr_data[GAIN_W-1:0];
            CSR_MIN_RTO:   min_rto_ff  <= csr_data[SAMPLE_BITS-1:0];
            CSR_INIT_RTO:  init_rto_ff <= csr_data[SAMPLE_BITS-1:0];
            default:       rej_ff      <= rej_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff    <= 1'b0;
         srtt_ff    <= SRTT_W'(8000000);
         mdev_ff    <= '0;
         avg_ff     <= '0;
         started_ff <= '{default: 1'b0};
         wmin_ff    <= '{default: '0};
         wmax_ff    <= '{default: '0};
         wend_ff    <= '{default: '0};
         mine_ff    <= '{default: '0};
         maxe_ff    <= '{default: '0};
         cnt_ff     <= '{default: '0};
      end else begin
         have_ff    <= have_in;
         srtt_ff    <= srtt_in;
         mdev_ff    <= mdev_in;
         avg_ff     <= avg_in;
         started_ff <= started_in;
         wmin_ff    <= wmin_in;
         wmax_ff    <= wmax_in;
         wend_ff    <= wend_in;
         mine_ff    <= mine_in;
         maxe_ff    <= maxe_in;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      used_ff  <= used_in;
      diff_ff  <= diff_in;
      up_ff    <= up_in;
      acc_ff   <= acc_in;
      wcand_ff <= wcand_in;
      hmin_ff  <= hmin_in;
      hmax_ff  <= hmax_in;
      buf_ff   <= buf_in;
      pass_ff  <= pass_in;
      rsp_ff   <= rsp_in;
   end

endmodule

FILE: src/rtt_rto_estimator_with_minmax_filter_unit.sv
// Top level of the RTT/RTO estimator with windowed min/max filters.
// Depends on rre_pkg, the interfaces in rre_if, rre_ctrl and rre_dpath.
//
// One word is processed at a time and gives one response word. From IDLE, which accepts
// it, an ignored sample goes through PREP to OUT; a one-way delay sample through PREP,
// WL0, WL1, WEND, FILT and OUT; a first round-trip sample adds RTT after PREP, and a later
// one RTT, MUL0, MUL1 and AVG. The next request is accepted once the unit is back in
// IDLE. Closing a round-trip window with outlier rejection adds SORT_LD, the median sort
// (one odd-even pass per cycle over the five stored window maxima) and MED before OUT.
// The shared 21x16 multiplier works on the average gain in MUL0 and MUL1 and on the
// window length in WL0 and WL1. Register writes are taken in any cycle, and the response
// register lets the next request in while a result waits; OUT waits until it is free.
module rtt_rto_estimator_with_minmax_filter_unit (
   input logic   clock,
   input logic   reset,
   rre_req_if.sink   req_if,
   rre_rsp_if.source rsp_if,
   rre_csr_if.sink   csr_if
);
   import rre_pkg::*;

   op_type        op;
   dp_status_type status;
   req_word_type  req_word;
   rsp_word_type  rsp_word;

   assign req_word.func              = req_if.func;
   assign req_word.now_us            = req_if.now_us;
   assign req_word.sample_us         = req_if.sample_us;
   assign req_word.rexmit_multiplier = req_if.rexmit_multiplier;
   assign csr_if.ready               = 1'b1;

   rre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .op        (op)
   );

   rre_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .req_word  (req_word),
      .csr_write (csr_if.valid),
      .csr_index (csr_if.index),
      .csr_data  (csr_if.data),
      .status    (status),
      .rsp_word  (rsp_word)
   );

   assign rsp_if.estimator_ready = rsp_word.estimator_ready;
   assign rsp_if.sample_used     = rsp_word.sample_used;
   assign rsp_if.srtt_out_us     = rsp_word.srtt_out_us;
   assign rsp_if.mdev_out_us     = rsp_word.mdev_out_us;
   assign rsp_if.rto_us          = rsp_word.rto_us;
   assign rsp_if.fast_rexmit_us  = rsp_word.fast_rexmit_us;
   assign rsp_if.rexmit_us       = rsp_word.rexmit_us;
   assign rsp_if.rtt_min_est_us  = rsp_word.rtt_min_est_us;
   assign rsp_if.rtt_max_est_us  = rsp_word.rtt_max_est_us;
   assign rsp_if.owd_min_est_us  = rsp_word.owd_min_est_us;
   assign rsp_if.owd_max_est_us  = rsp_word.owd_max_est_us;

endmodule
